// ===== sv/htc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htc_pkg: shared types and constants of the sensor calibration block
// Widths of the datapath, register indexes and the lane interface structs.
// ----------------------------------------------------------------------------
package htc_pkg;

   localparam int FRAC_BITS = 8;
   localparam int SAMPLE_W  = 16;
   localparam int RH_PT_W   = 8;
   localparam int PT_W      = 10;
   localparam int VALUE_W   = 32;
   localparam int DIFF_W    = SAMPLE_W + 1;
   localparam int DPT_W     = PT_W + 1;
   localparam int PROD_W    = DIFF_W + DPT_W;
   localparam int SUM_W     = PROD_W + 1;
   localparam int NUM_W     = SUM_W + FRAC_BITS;
   localparam int MAG_W     = NUM_W - 1;
   localparam int SHIFT_W   = 2;
   localparam int DEN_W     = SAMPLE_W + 3;
   localparam int REM_W     = DEN_W + 1;
   localparam int LANE_LAT  = 3 + MAG_W + 1;

   localparam logic [SHIFT_W-1:0] RH_UNIT_SHIFT = 2'd1;
   localparam logic [SHIFT_W-1:0] T_UNIT_SHIFT  = 2'd3;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_RH_LO_PT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RH_HI_PT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RH_LO_RAW = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RH_HI_RAW = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_T_LO_PT   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_T_HI_PT   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_T_LO_RAW  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_T_HI_RAW  = 3'd7;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] raw_lo;
      logic signed [SAMPLE_W-1:0] raw_hi;
      logic [PT_W-1:0]            pt_lo;
      logic [PT_W-1:0]            pt_hi;
      logic [SHIFT_W-1:0]         unit_shift;
   } lane_cal_type;

   typedef struct packed {
      logic neg;
      logic zero;
   } div_tag_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      span_zero;
   } lane_res_type;

endpackage

// ===== sv/htc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htc_if: handshake channels of the sensor calibration block
// Sample request, calibrated response and register write channels.
// ----------------------------------------------------------------------------
interface htc_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [htc_pkg::SAMPLE_W-1:0]  humidity_sample;
   logic signed [htc_pkg::SAMPLE_W-1:0]  temperature_sample;
   modport source (output valid, humidity_sample, temperature_sample, input ready);
   modport sink   (input valid, humidity_sample, temperature_sample, output ready);
endinterface

interface htc_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [htc_pkg::VALUE_W-1:0]   humidity_value;
   logic signed [htc_pkg::VALUE_W-1:0]   temperature_value;
   logic                                 humidity_span_zero;
   logic                                 temperature_span_zero;
   modport source (output valid, humidity_value, temperature_value, humidity_span_zero,
                   temperature_span_zero, input ready);
   modport sink   (input valid, humidity_value, temperature_value, humidity_span_zero,
                   temperature_span_zero, output ready);
endinterface

interface htc_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [htc_pkg::CSR_IDX_W-1:0]        index;
   logic [htc_pkg::CSR_DATA_W-1:0]       data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/humidity_temperature_calibration_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_temperature_calibration_top: two-point sensor calibration
// Maps a raw humidity and temperature sample pair onto calibrated fixed-point
// values through two lanes that run side by side, then merges the results.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  req_chan  in         raw humidity and temperature samples
//  rsp_chan  out        calibrated values and zero-span flags
//  csr_chan  in         calibration register writes, index 0 to 7
//
// One request is taken every cycle while the response side keeps up. A request
// passes through three registers of differences, products and magnitudes, one
// divider stage per quotient bit, a saturation register and the merging
// response register. Reset is synchronous and clears the valid pipeline and
// all calibration registers to zero; both ready outputs are held low while
// reset is high. A stall on the response side freezes the whole pipeline, so
// ready follows it.
// ----------------------------------------------------------------------------
module humidity_temperature_calibration_top (
   input  logic       clock,
   input  logic       reset,
   htc_req_if.sink    req_chan,
   htc_rsp_if.source  rsp_chan,
   htc_csr_if.sink    csr_chan
);

   // Calibration registers, held at their architectural widths.
   logic [htc_pkg::RH_PT_W-1:0]         rh_lo_pt_ff, rh_hi_pt_ff;
   logic signed [htc_pkg::SAMPLE_W-1:0] rh_lo_raw_ff, rh_hi_raw_ff;
   logic [htc_pkg::PT_W-1:0]            t_lo_pt_ff, t_hi_pt_ff;
   logic signed [htc_pkg::SAMPLE_W-1:0] t_lo_raw_ff, t_hi_raw_ff;

   // Valid bit of each lane stage plus the response register.
   logic [htc_pkg::LANE_LAT-1:0] valid_ff;
   logic [htc_pkg::LANE_LAT-1:0] valid_in;
   logic                         rsp_valid_ff;
   logic                         en;

   htc_pkg::lane_cal_type rh_cal, t_cal;
   htc_pkg::lane_res_type rh_res, t_res;
   htc_pkg::lane_res_type rh_out_ff, t_out_ff;

   // Register writes are always taken outside reset; an index beyond the list
   // does not exist.
   assign csr_chan.ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         rh_lo_pt_ff  <= '0;
         rh_hi_pt_ff  <= '0;
         rh_lo_raw_ff <= '0;
         rh_hi_raw_ff <= '0;
         t_lo_pt_ff   <= '0;
         t_hi_pt_ff   <= '0;
         t_lo_raw_ff  <= '0;
         t_hi_raw_ff  <= '0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            htc_pkg::REG_RH_LO_PT:  rh_lo_pt_ff  <= csr_chan.data[htc_pkg::RH_PT_W-1:0];
            htc_pkg::REG_RH_HI_PT:  rh_hi_pt_ff  <= csr_chan.data[htc_pkg::RH_PT_W-1:0];
            htc_pkg::REG_RH_LO_RAW: rh_lo_raw_ff <= csr_chan.data;
            htc_pkg::REG_RH_HI_RAW: rh_hi_raw_ff <= csr_chan.data;
            htc_pkg::REG_T_LO_PT:   t_lo_pt_ff   <= csr_chan.data[htc_pkg::PT_W-1:0];
            htc_pkg::REG_T_HI_PT:   t_hi_pt_ff   <= csr_chan.data[htc_pkg::PT_W-1:0];
            htc_pkg::REG_T_LO_RAW:  t_lo_raw_ff  <= csr_chan.data;
            htc_pkg::REG_T_HI_RAW:  t_hi_raw_ff  <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // Humidity points are half percent, so the denominator is scaled by two;
   // temperature points are eighth degrees, scaled by eight.
   assign rh_cal.raw_lo     = rh_lo_raw_ff;
   assign rh_cal.raw_hi     = rh_hi_raw_ff;
   assign rh_cal.pt_lo      = htc_pkg::PT_W'(rh_lo_pt_ff);
   assign rh_cal.pt_hi      = htc_pkg::PT_W'(rh_hi_pt_ff);
   assign rh_cal.unit_shift = htc_pkg::RH_UNIT_SHIFT;

   assign t_cal.raw_lo      = t_lo_raw_ff;
   assign t_cal.raw_hi      = t_hi_raw_ff;
   assign t_cal.pt_lo       = t_lo_pt_ff;
   assign t_cal.pt_hi       = t_hi_pt_ff;
   assign t_cal.unit_shift  = htc_pkg::T_UNIT_SHIFT;

   // The pipeline advances whenever the response register is empty or drains.
   assign en             = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = en && !reset;

   htc_lane u_rh_lane (
      .clock  (clock),
      .en     (en),
      .sample (req_chan.humidity_sample),
      .cal    (rh_cal),
      .res    (rh_res)
   );

   htc_lane u_t_lane (
      .clock  (clock),
      .en     (en),
      .sample (req_chan.temperature_sample),
      .cal    (t_cal),
      .res    (t_res)
   );

   assign valid_in = {valid_ff[htc_pkg::LANE_LAT-2:0], req_chan.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= valid_ff[htc_pkg::LANE_LAT-1];
      end
   end

   // Merging stage: both lanes finish in the same cycle and form one response.
   always_ff @(posedge clock) begin
      if (en) begin
         rh_out_ff <= rh_res;
         t_out_ff  <= t_res;
      end
   end

   assign rsp_chan.valid                 = rsp_valid_ff;
   assign rsp_chan.humidity_value        = rh_out_ff.value;
   assign rsp_chan.temperature_value     = t_out_ff.value;
   assign rsp_chan.humidity_span_zero    = rh_out_ff.span_zero;
   assign rsp_chan.temperature_span_zero = t_out_ff.span_zero;

endmodule

// ===== sv/htc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htc_div: pipelined restoring divider on magnitudes
// One quotient bit per stage; a tag travels alongside each operand pair.
// ----------------------------------------------------------------------------
module htc_div (
   input  logic                         clock,
   input  logic                         en,
   input  logic [htc_pkg::MAG_W-1:0]    num_mag,
   input  logic [htc_pkg::DEN_W-1:0]    den_mag,
   input  htc_pkg::div_tag_type         tag,
   output logic [htc_pkg::MAG_W-1:0]    quo,
   output htc_pkg::div_tag_type         tag_out
);

   localparam int N = htc_pkg::MAG_W;

   logic [htc_pkg::DEN_W-1:0] rem_ff [N];
   logic [htc_pkg::MAG_W-1:0] num_ff [N];
   logic [htc_pkg::MAG_W-1:0] quo_ff [N];
   logic [htc_pkg::DEN_W-1:0] den_ff [N];
   htc_pkg::div_tag_type      tag_ff [N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic [htc_pkg::DEN_W-1:0] rem_cur;
      logic [htc_pkg::MAG_W-1:0] num_cur;
      logic [htc_pkg::MAG_W-1:0] quo_cur;
      logic [htc_pkg::DEN_W-1:0] den_cur;
      htc_pkg::div_tag_type      tag_cur;
      logic [htc_pkg::REM_W-1:0] trial;
      logic                      fits;

      if (k == 0) begin : g_head
         assign rem_cur = '0;
         assign num_cur = num_mag;
         assign quo_cur = '0;
         assign den_cur = den_mag;
         assign tag_cur = tag;
      end else begin : g_body
         assign rem_cur = rem_ff[k-1];
         assign num_cur = num_ff[k-1];
         assign quo_cur = quo_ff[k-1];
         assign den_cur = den_ff[k-1];
         assign tag_cur = tag_ff[k-1];
      end

      assign trial = {rem_cur, num_cur[htc_pkg::MAG_W-1]};
      assign fits  = trial >= {1'b0, den_cur};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= fits ? htc_pkg::DEN_W'(trial - {1'b0, den_cur})
                              : trial[htc_pkg::DEN_W-1:0];
            num_ff[k] <= {num_cur[htc_pkg::MAG_W-2:0], 1'b0};
            quo_ff[k] <= {quo_cur[htc_pkg::MAG_W-2:0], fits};
            den_ff[k] <= den_cur;
            tag_ff[k] <= tag_cur;
         end
      end
   end

   assign quo     = quo_ff[N-1];
   assign tag_out = tag_ff[N-1];

endmodule

// ===== sv/htc_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htc_lane: one calibration lane
// Forms numerator and denominator of the two-point line, divides, saturates.
// ----------------------------------------------------------------------------
module htc_lane (
   input  logic                                clock,
   input  logic                                en,
   input  logic signed [htc_pkg::SAMPLE_W-1:0] sample,
   input  htc_pkg::lane_cal_type               cal,
   output htc_pkg::lane_res_type               res
);

   logic signed [htc_pkg::DIFF_W-1:0] diff_ff, span_ff, span2_ff;
   logic signed [htc_pkg::DPT_W-1:0]  dpt_ff;
   logic [htc_pkg::PT_W-1:0]          ptlo_ff;
   logic [htc_pkg::SHIFT_W-1:0]       shift_ff, shift2_ff;
   logic signed [htc_pkg::PROD_W-1:0] slope_ff, base_ff;
   logic [htc_pkg::MAG_W-1:0]         mag_ff;
   logic [htc_pkg::DEN_W-1:0]         den_ff;
   htc_pkg::div_tag_type              tag_ff;
   htc_pkg::lane_res_type             res_ff;

   logic signed [htc_pkg::SUM_W-1:0]  sum;
   logic signed [htc_pkg::NUM_W-1:0]  num;
   logic [htc_pkg::NUM_W-1:0]         num_abs;
   logic [htc_pkg::DIFF_W-1:0]        span_abs;
   logic [htc_pkg::MAG_W-1:0]         quo;
   htc_pkg::div_tag_type              tag_q;
   logic signed [htc_pkg::NUM_W-1:0]  q_signed;
   logic signed [htc_pkg::VALUE_W-1:0] value_in;

   // Stage 1: differences.
   always_ff @(posedge clock) begin
      if (en) begin
         diff_ff  <= htc_pkg::DIFF_W'(sample) - htc_pkg::DIFF_W'(cal.raw_lo);
         span_ff  <= htc_pkg::DIFF_W'(cal.raw_hi) - htc_pkg::DIFF_W'(cal.raw_lo);
         dpt_ff   <= $signed({1'b0, cal.pt_hi}) - $signed({1'b0, cal.pt_lo});
         ptlo_ff  <= cal.pt_lo;
         shift_ff <= cal.unit_shift;
      end
   end

   // Stage 2: the two products of the numerator.
   always_ff @(posedge clock) begin
      if (en) begin
         slope_ff  <= htc_pkg::PROD_W'(diff_ff * dpt_ff);
         base_ff   <= htc_pkg::PROD_W'($signed({1'b0, ptlo_ff}) * span_ff);
         span2_ff  <= span_ff;
         shift2_ff <= shift_ff;
      end
   end

   // Stage 3: magnitudes and quotient sign for the divider.
   assign sum      = htc_pkg::SUM_W'(slope_ff) + htc_pkg::SUM_W'(base_ff);
   assign num      = htc_pkg::NUM_W'(sum) <<< htc_pkg::FRAC_BITS;
   assign num_abs  = num[htc_pkg::NUM_W-1] ? htc_pkg::NUM_W'(-num) : htc_pkg::NUM_W'(num);
   assign span_abs = span2_ff[htc_pkg::DIFF_W-1] ? htc_pkg::DIFF_W'(-span2_ff)
                                                 : htc_pkg::DIFF_W'(span2_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff      <= num_abs[htc_pkg::MAG_W-1:0];
         den_ff      <= htc_pkg::DEN_W'(span_abs[htc_pkg::SAMPLE_W-1:0]) << shift2_ff;
         tag_ff.neg  <= num[htc_pkg::NUM_W-1] ^ span2_ff[htc_pkg::DIFF_W-1];
         tag_ff.zero <= span2_ff == '0;
      end
   end

   htc_div u_div (
      .clock   (clock),
      .en      (en),
      .num_mag (mag_ff),
      .den_mag (den_ff),
      .tag     (tag_ff),
      .quo     (quo),
      .tag_out (tag_q)
   );

   // Final stage: sign, saturation to 32 bits, zero span.
   assign q_signed = tag_q.neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

   always_comb begin
      if (tag_q.zero) begin
         value_in = '0;
      end else if (q_signed > $signed(htc_pkg::NUM_W'({1'b0, {(htc_pkg::VALUE_W-1){1'b1}}}))) begin
         value_in = {1'b0, {(htc_pkg::VALUE_W-1){1'b1}}};
      end else if (q_signed < -$signed(htc_pkg::NUM_W'({1'b1, {(htc_pkg::VALUE_W-1){1'b0}}}))) begin
         value_in = {1'b1, {(htc_pkg::VALUE_W-1){1'b0}}};
      end else begin
         value_in = q_signed[htc_pkg::VALUE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff.value     <= value_in;
         res_ff.span_zero <= tag_q.zero;
      end
   end

   assign res = res_ff;

endmodule

// ===== verif/humidity_temperature_calibration_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_temperature_calibration_top_tb: self-checking bench of the block
// Drives sample pairs under several calibration settings and idle patterns,
// predicts each calibrated reading in the bench or takes it from the directed
// table for typed rows, and checks every response.
module humidity_temperature_calibration_top_tb;

   localparam int PIPE_LAT    = htc_pkg::LANE_LAT + 1;
   localparam int CYCLE_LIMIT = 400000;
   localparam int NUM_CFGS    = 5;
   localparam int NUM_ROWS    = 16;
   localparam int RAND_ITEMS  = 125;

   typedef struct {
      logic signed [htc_pkg::VALUE_W-1:0] rh;
      logic signed [htc_pkg::VALUE_W-1:0] tv;
      logic                               rz;
      logic                               tz;
   } reading_type;

   typedef struct {
      int           cfg;
      logic [15:0]  h;
      logic [15:0]  t;
      bit           typed;
      reading_type  res;
   } dir_row_type;

   logic clock;
   logic reset;

   htc_req_if req ();
   htc_rsp_if rsp ();
   htc_csr_if csr ();

   humidity_temperature_calibration_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp),
      .csr_chan (csr)
   );

   // Mirror of the calibration registers, updated on each accepted write.
   logic [15:0] cal_regs [8];
   reading_type pending_readings [$];
   int          errors;
   int          cycles;
   int          requests_sent;
   int          readings_checked;
   int          recv_stall_pct;
   int          send_idle_pct;

   // The expectation of the request on the bus; typed rows bypass the predictor.
   bit          cur_typed;
   reading_type cur_reading;

   // Raw write data of each directed setting; bits above a register's width
   // are set in the last one to show that they are dropped.
   logic [15:0] cfg_tab [NUM_CFGS][8] = '{
      '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
      '{16'h0000, 16'h00FF, 16'h8000, 16'h7FFF, 16'h0000, 16'h03FF, 16'h8000, 16'h7FFF},
      '{16'h00FF, 16'h0000, 16'h7FFF, 16'h8000, 16'h03FF, 16'h0000, 16'h7FFF, 16'h8000},
      '{16'h0000, 16'h00FF, 16'h0000, 16'h0001, 16'h0000, 16'h03FF, 16'hFFFF, 16'h0000},
      '{16'hFF40, 16'hFFC8, 16'h0064, 16'h0064, 16'hFC10, 16'hFFFF, 16'hF000, 16'h1000}
   };

   dir_row_type dir_rows [NUM_ROWS] = '{
      '{0, 16'h8000, 16'h7FFF, 1'b1, '{32'sd0, 32'sd0, 1'b1, 1'b1}},
      '{0, 16'h0000, 16'h0000, 1'b1, '{32'sd0, 32'sd0, 1'b1, 1'b1}},
      '{0, 16'h7FFF, 16'h8000, 1'b1, '{32'sd0, 32'sd0, 1'b1, 1'b1}},
      '{1, 16'h8000, 16'h8000, 1'b1, '{32'sd0, 32'sd0, 1'b0, 1'b0}},
      '{1, 16'h7FFF, 16'h7FFF, 1'b1, '{32'sd32640, 32'sd32736, 1'b0, 1'b0}},
      '{1, 16'h0000, 16'h0000, 1'b0, '{32'sd0, 32'sd0, 1'b0, 1'b0}},
      '{1, 16'hFFFF, 16'h0001, 1'b0, '{32'sd0, 32'sd0, 1'b0, 1'b0}},
      '{2, 16'h8000, 16'h8000, 1'b1, '{32'sd0, 32'sd0, 1'b0, 1'b0}},
      '{2, 16'h7FFF, 16'h7FFF, 1'b1, '{32'sd32640, 32'sd32736, 1'b0, 1'b0}},
      '{2, 16'h5555, 16'hAAAA, 1'b0, '{32'sd0, 32'sd0, 1'b0, 1'b0}},
      '{3, 16'h7FFF, 16'h7FFF, 1'b0, '{32'sd0, 32'sd0, 1'b0, 1'b0}},
      '{3, 16'h8000, 16'h8000, 1'b0, '{32'sd0, 32'sd0, 1'b0, 1'b0}},
      '{3, 16'h0001, 16'h0000, 1'b0, '{32'sd0, 32'sd0, 1'b0, 1'b0}},
      '{4, 16'h0000, 16'h0000, 1'b0, '{32'sd0, 32'sd0, 1'b0, 1'b0}},
      '{4, 16'h1234, 16'h8000, 1'b0, '{32'sd0, 32'sd0, 1'b0, 1'b0}},
      '{4, 16'h8000, 16'h7FFF, 1'b0, '{32'sd0, 32'sd0, 1'b0, 1'b0}}
   };

   // Two-point line through (raw_lo, pt_lo) and (raw_hi, pt_hi), scaled by
   // 2^FRAC_BITS / unit, truncated toward zero and clamped to 32 bits.
   function automatic logic signed [htc_pkg::VALUE_W-1:0] calibrate_lane(
      input logic signed [15:0] s, input logic signed [15:0] raw_lo,
      input logic signed [15:0] raw_hi, input longint pt_lo, input longint pt_hi,
      input longint unit, output logic span_zero);
      longint d;
      longint num;
      longint q;
      d = longint'(raw_hi) - longint'(raw_lo);
      span_zero = (d == 0);
      if (d == 0) begin
         return '0;
      end
      num = (longint'(s) - longint'(raw_lo)) * (pt_hi - pt_lo)
            * (longint'(1) << htc_pkg::FRAC_BITS)
            + pt_lo * (longint'(1) << htc_pkg::FRAC_BITS) * d;
      q = num / (d * unit);
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      return q[htc_pkg::VALUE_W-1:0];
   endfunction

   function automatic reading_type predict_reading(input logic [15:0] h,
                                                   input logic [15:0] t);
      reading_type r;
      r.rh = calibrate_lane(h, cal_regs[htc_pkg::REG_RH_LO_RAW],
                            cal_regs[htc_pkg::REG_RH_HI_RAW],
                            longint'(cal_regs[htc_pkg::REG_RH_LO_PT][htc_pkg::RH_PT_W-1:0]),
                            longint'(cal_regs[htc_pkg::REG_RH_HI_PT][htc_pkg::RH_PT_W-1:0]),
                            2, r.rz);
      r.tv = calibrate_lane(t, cal_regs[htc_pkg::REG_T_LO_RAW],
                            cal_regs[htc_pkg::REG_T_HI_RAW],
                            longint'(cal_regs[htc_pkg::REG_T_LO_PT][htc_pkg::PT_W-1:0]),
                            longint'(cal_regs[htc_pkg::REG_T_HI_PT][htc_pkg::PT_W-1:0]),
                            8, r.tz);
      return r;
   endfunction

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d readings pending", $time, cycles,
                  pending_readings.size());
         $display("FAILURE");
         $finish;
      end
   end

   // Register mirror follows every accepted write.
   always @(posedge clock) begin
      if (!reset && csr.valid && csr.ready) begin
         cal_regs[csr.index] <= csr.data;
      end
   end

   // Each accepted request queues its expected reading.
   always @(posedge clock) begin
      if (!reset && req.valid && req.ready) begin
         pending_readings.push_back(cur_typed ? cur_reading :
                                    predict_reading(req.humidity_sample, req.temperature_sample));
         requests_sent++;
      end
   end

   // Each accepted response is compared field by field with the oldest expectation.
   always @(posedge clock) begin
      reading_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_readings.size() == 0) begin
            $display("%0t: response with nothing expected, rh %0d t %0d", $time,
                     rsp.humidity_value, rsp.temperature_value);
            errors++;
         end else begin
            e = pending_readings.pop_front();
            readings_checked++;
            if (rsp.humidity_value !== e.rh) begin
               $display("%0t: humidity_value expected %0d actual %0d", $time, e.rh,
                        rsp.humidity_value);
               errors++;
            end
            if (rsp.temperature_value !== e.tv) begin
               $display("%0t: temperature_value expected %0d actual %0d", $time, e.tv,
                        rsp.temperature_value);
               errors++;
            end
            if (rsp.humidity_span_zero !== e.rz) begin
               $display("%0t: humidity_span_zero expected %b actual %b", $time, e.rz,
                        rsp.humidity_span_zero);
               errors++;
            end
            if (rsp.temperature_span_zero !== e.tz) begin
               $display("%0t: temperature_span_zero expected %b actual %b", $time, e.tz,
                        rsp.temperature_span_zero);
               errors++;
            end
         end
      end
   end

   // The response side stalls at the rate of the current phase.
   always @(negedge clock) begin
      rsp.ready = ($urandom_range(99) >= recv_stall_pct);
   end

   // Tasks below are entered and left just after a falling edge.
   task automatic write_reg(input logic [htc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [15:0] value);
      csr.valid = 1'b1;
      csr.index = idx;
      csr.data  = value;
      do @(posedge clock); while (!csr.ready);
      @(negedge clock);
      csr.valid = 1'b0;
   endtask

   // Lets the pipeline run dry so the registers can be written safely.
   task automatic drain_readings();
      req.valid = 1'b0;
      while (pending_readings.size() != 0) @(negedge clock);
      repeat (PIPE_LAT + 4) @(negedge clock);
   endtask

   task automatic send_request(input logic [15:0] h, input logic [15:0] t, input bit typed,
                               input reading_type res);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid = 1'b0;
         @(negedge clock);
      end
      cur_typed              = typed;
      cur_reading            = res;
      req.humidity_sample    = h;
      req.temperature_sample = t;
      req.valid              = 1'b1;
      do @(posedge clock); while (!req.ready);
      @(negedge clock);
   endtask

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return 16'($urandom_range(65535));
      endcase
   endfunction

   initial begin
      int          cur_cfg;
      int          send_tab [4];
      int          stall_tab [4];
      logic [15:0] v;
      reading_type none;

      send_tab  = '{0, 63, 0, 31};
      stall_tab = '{0, 0, 63, 31};
      none      = '{32'sd0, 32'sd0, 1'b0, 1'b0};
      errors = 0;
      cycles = 0;
      requests_sent = 0;
      readings_checked = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      cur_typed = 1'b0;
      cur_reading = none;
      foreach (cal_regs[i]) cal_regs[i] = '0;
      req.valid = 1'b0;
      req.humidity_sample = '0;
      req.temperature_sample = '0;
      csr.valid = 1'b0;
      csr.index = '0;
      csr.data = '0;
      rsp.ready = 1'b1;
      reset = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: reset state, full-range rising and falling lines, a
      // one-count span, and one lane with equal raw points plus dropped bits.
      cur_cfg = 0;
      foreach (dir_rows[r]) begin
         if (dir_rows[r].cfg != cur_cfg) begin
            drain_readings();
            cur_cfg = dir_rows[r].cfg;
            for (int i = 0; i < 8; i++)
               write_reg(i[htc_pkg::CSR_IDX_W-1:0], cfg_tab[cur_cfg][i]);
         end
         send_request(dir_rows[r].h, dir_rows[r].t, dir_rows[r].typed, dir_rows[r].res);
      end

      // Random part: a fresh random setting for each idle pattern.
      for (int ph = 0; ph < 4; ph++) begin
         drain_readings();
         for (int i = 0; i < 8; i++) begin
            v = 16'($urandom_range(65535));
            // Now and then make a lane's raw points equal.
            if ((i == htc_pkg::REG_RH_HI_RAW || i == htc_pkg::REG_T_HI_RAW) &&
                $urandom_range(3) == 0)
               v = cal_regs[i-1];
            write_reg(i[htc_pkg::CSR_IDX_W-1:0], v);
         end
         send_idle_pct  = send_tab[ph];
         recv_stall_pct = stall_tab[ph];
         for (int n = 0; n < RAND_ITEMS; n++) begin
            // Once, the sender holds off until every reading is back.
            if (ph == 1 && n == RAND_ITEMS / 2) begin
               req.valid = 1'b0;
               while (pending_readings.size() != 0) @(negedge clock);
            end
            send_request(pick_sample(), pick_sample(), 1'b0, none);
         end
      end

      req.valid = 1'b0;
      while (pending_readings.size() != 0) @(negedge clock);
      repeat (2 * PIPE_LAT) @(negedge clock);

      $display("Sent %0d sample pairs over %0d directed and 4 random settings,", requests_sent,
               NUM_CFGS);
      $display("checked %0d calibrated readings under four idle and stall patterns.",
               readings_checked);
      if (errors == 0 && pending_readings.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
